@@ rtl/tli_pkg.sv @@
// Shared widths, codes and the queue item type of the table linear interpolator.
package tli_pkg;

   // Field widths
   localparam int RES_W  = 24;
   localparam int TEMP_W = 19;
   localparam int CSR_W  = 11;
   localparam int IDX_W  = 10;

   // Interpolation datapath widths
   localparam int DIFF_T_W = TEMP_W + 1;
   localparam int DIFF_R_W = RES_W + 1;
   localparam int PROD_W   = DIFF_T_W + DIFF_R_W;
   localparam int MAG_W    = PROD_W - 1;
   localparam int SUM_W    = MAG_W + 2;

   // Item kinds
   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_CONVERT = 1'b1;

   // Result saturation limits
   localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sh3FFFF;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN = 19'sh40000;

   // One classified item waiting between front and back
   typedef struct packed {
      logic              convert;
      logic [RES_W-1:0]  resistance;
      logic [TEMP_W-1:0] temperature;
   } queue_item_type;

endpackage

@@ rtl/tli_front.sv @@
// Front end: accepts items, drops out-of-range loads and queues the rest.
module tli_front #(
   parameter int  TABLE_DEPTH = 1024,
   localparam int ADDR_W      = $clog2(TABLE_DEPTH)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [tli_pkg::IDX_W-1:0]        req_entry_index,
   input  logic [tli_pkg::RES_W-1:0]        req_entry_resistance,
   input  logic signed [tli_pkg::TEMP_W-1:0] req_entry_temperature,
   input  logic [tli_pkg::RES_W-1:0]        req_measured_resistance,
   output logic                             q_valid,
   output tli_pkg::queue_item_type          q_item,
   output logic [ADDR_W-1:0]                q_addr,
   input  logic                             q_pop
);
   import tli_pkg::*;

   queue_item_type    item_mem [2];
   logic [ADDR_W-1:0] addr_mem [2];
   logic              wptr_ff, wptr_in;
   logic              rptr_ff, rptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              accept, in_range, push;
   queue_item_type    new_item;

   // Classify the incoming item
   assign req_stall = (cnt_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign in_range  = 32'(req_entry_index) < TABLE_DEPTH;
   assign push      = accept && (req_type == REQ_CONVERT || in_range);

   always_comb begin
      new_item.convert     = req_type;
      new_item.resistance  = (req_type == REQ_CONVERT) ? req_measured_resistance
                                                       : req_entry_resistance;
      new_item.temperature = req_entry_temperature;
   end

   // Two-entry queue
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = item_mem[rptr_ff];
   assign q_addr  = addr_mem[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         wptr_in = !wptr_ff;
      end
      if (q_pop) begin
         rptr_in = !rptr_ff;
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_mem[wptr_ff] <= new_item;
         addr_mem[wptr_ff] <= ADDR_W'(req_entry_index);
      end
   end

   // Checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("queue fill above two");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !q_pop |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queued item not counted");

   a_drop_load: assert property (@(posedge clock) disable iff (reset)
      accept && req_type == REQ_LOAD && !in_range
      |=> cnt_ff == ($past(q_pop) ? $past(cnt_ff) - 2'd1 : $past(cnt_ff)))
      else $error("out-of-range load entered the queue");

endmodule

@@ rtl/tli_div.sv @@
// Restoring divider, one quotient bit per cycle.
module tli_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tli_pkg::MAG_W-1:0]   dividend,
   input  logic [tli_pkg::RES_W-1:0]   divisor,
   output logic                        busy,
   output logic                        done,
   output logic [tli_pkg::MAG_W-1:0]   quotient
);
   import tli_pkg::*;

   localparam int CNT_W = $clog2(MAG_W + 1);

   logic [MAG_W-1:0] quo_ff, quo_in;
   logic [RES_W-1:0] rem_ff, rem_in;
   logic [RES_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [RES_W:0]   trial;
   logic [RES_W+1:0] diff;

   // Trial subtraction of the shifted remainder
   assign trial = {rem_ff, quo_ff[MAG_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(MAG_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[RES_W+1]) begin
            rem_in = diff[RES_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in = trial[RES_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/tli_back.sv @@
// Back end: table memory, binary search, interpolation and result register.
module tli_back #(
   parameter int  TABLE_DEPTH = 1024,
   localparam int ADDR_W      = $clog2(TABLE_DEPTH),
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  tli_pkg::queue_item_type           q_item,
   input  logic [ADDR_W-1:0]                 q_addr,
   output logic                              q_pop,
   input  logic [CNT_W-1:0]                  n_used,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [tli_pkg::TEMP_W-1:0] rsp_temperature
);
   import tli_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PROBE = 4'd1;
   localparam logic [3:0] S_CMP   = 4'd2;
   localparam logic [3:0] S_PICK  = 4'd3;
   localparam logic [3:0] S_LO    = 4'd4;
   localparam logic [3:0] S_HI    = 4'd5;
   localparam logic [3:0] S_MUL   = 4'd6;
   localparam logic [3:0] S_ABS   = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   // Table memory
   logic [RES_W-1:0]  res_mem [TABLE_DEPTH];
   logic [TEMP_W-1:0] tmp_mem [TABLE_DEPTH];
   logic [RES_W-1:0]  rd_res_ff;
   logic [TEMP_W-1:0] rd_tmp_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;

   // Control and datapath registers
   logic [3:0]                state_ff, state_in;
   logic [RES_W-1:0]          sample_ff, sample_in;
   logic [CNT_W-1:0]          first_ff, first_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      single_ff, single_in;
   logic [RES_W-1:0]          r_lo_ff, r_lo_in, r_hi_ff, r_hi_in;
   logic signed [TEMP_W-1:0]  t_lo_ff, t_lo_in, t_hi_ff, t_hi_in;
   logic [RES_W-1:0]          den_ff, den_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic                      neg_ff, neg_in;
   logic signed [TEMP_W-1:0]  res_ff, res_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [TEMP_W-1:0]  rsp_temp_ff, rsp_temp_in;

   logic [CNT_W-1:0]          step, probe;
   logic [DIFF_R_W-1:0]       den_full;
   logic signed [DIFF_T_W-1:0] diff_t;
   logic signed [DIFF_R_W-1:0] diff_r;
   logic [PROD_W-1:0]         prod_abs;
   logic signed [SUM_W-1:0]   sum;
   logic                      res_load;

   logic                      div_start, div_busy, div_done;
   logic [MAG_W-1:0]          div_quotient;

   tli_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_abs[MAG_W-1:0]),
      .divisor  (den_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         res_mem[q_addr] <= q_item.resistance;
         tmp_mem[q_addr] <= q_item.temperature;
      end
      rd_res_ff <= res_mem[rd_addr];
      rd_tmp_ff <= tmp_mem[rd_addr];
   end

   // Search probe
   assign step  = count_ff >> 1;
   assign probe = first_ff + step;

   // Interpolation arithmetic
   assign den_full = {1'b0, r_hi_ff} - {1'b0, r_lo_ff};
   assign diff_t   = DIFF_T_W'(t_hi_ff) - DIFF_T_W'(t_lo_ff);
   assign diff_r   = $signed({1'b0, sample_ff}) - $signed({1'b0, r_lo_ff});
   assign prod_abs = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign sum      = neg_ff ? SUM_W'(t_lo_ff) - $signed({2'b00, div_quotient})
                            : SUM_W'(t_lo_ff) + $signed({2'b00, div_quotient});

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      sample_in = sample_ff;
      first_in  = first_ff;
      count_in  = count_ff;
      single_in = single_ff;
      r_lo_in   = r_lo_ff;
      t_lo_in   = t_lo_ff;
      r_hi_in   = r_hi_ff;
      t_hi_in   = t_hi_ff;
      den_in    = den_ff;
      prod_in   = prod_ff;
      neg_in    = neg_ff;
      res_in    = res_ff;
      rd_addr   = '0;
      wr_en     = 1'b0;
      q_pop     = 1'b0;
      div_start = 1'b0;
      res_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.convert == REQ_CONVERT) begin
                  sample_in = q_item.resistance;
                  first_in  = '0;
                  count_in  = n_used;
                  state_in  = S_PROBE;
               end else begin
                  wr_en = 1'b1;
               end
            end
         end
         S_PROBE: begin
            if (count_ff == '0) begin
               state_in = S_PICK;
            end else begin
               rd_addr  = probe[ADDR_W-1:0];
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            rd_addr = probe[ADDR_W-1:0];
            if (!(sample_ff < rd_res_ff)) begin
               first_in = probe + CNT_W'(1);
               count_in = count_ff - step - CNT_W'(1);
            end else begin
               count_in = step;
            end
            state_in = S_PROBE;
         end
         S_PICK: begin
            if (first_ff >= n_used) begin
               rd_addr   = ADDR_W'(n_used - CNT_W'(1));
               single_in = 1'b1;
            end else if (first_ff == '0) begin
               rd_addr   = '0;
               single_in = 1'b1;
            end else begin
               rd_addr   = ADDR_W'(first_ff - CNT_W'(1));
               single_in = 1'b0;
            end
            state_in = S_LO;
         end
         S_LO: begin
            r_lo_in = rd_res_ff;
            t_lo_in = rd_tmp_ff;
            if (single_ff) begin
               res_in   = rd_tmp_ff;
               state_in = S_OUT;
            end else begin
               rd_addr  = first_ff[ADDR_W-1:0];
               state_in = S_HI;
            end
         end
         S_HI: begin
            r_hi_in  = rd_res_ff;
            t_hi_in  = rd_tmp_ff;
            state_in = S_MUL;
         end
         S_MUL: begin
            // Non-positive span gives the lower temperature
            if (den_full[DIFF_R_W-1] || den_full == '0) begin
               res_in   = t_lo_ff;
               state_in = S_OUT;
            end else begin
               den_in   = den_full[RES_W-1:0];
               prod_in  = PROD_W'(diff_t) * PROD_W'(diff_r);
               state_in = S_ABS;
            end
         end
         S_ABS: begin
            neg_in    = prod_ff[PROD_W-1];
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (sum > SUM_W'(TEMP_MAX)) begin
               res_in = TEMP_MAX;
            end else if (sum < SUM_W'(TEMP_MIN)) begin
               res_in = TEMP_MIN;
            end else begin
               res_in = sum[TEMP_W-1:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               res_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_temp_in  = rsp_temp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_temp_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      first_ff    <= first_in;
      count_ff    <= count_in;
      single_ff   <= single_in;
      r_lo_ff     <= r_lo_in;
      t_lo_ff     <= t_lo_in;
      r_hi_ff     <= r_hi_in;
      t_hi_ff     <= t_hi_in;
      den_ff      <= den_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      res_ff      <= res_in;
      rsp_temp_ff <= rsp_temp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = rsp_temp_ff;

   // Checks
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PROBE |-> 32'(first_ff) + 32'(count_ff) <= 32'(n_used))
      else $error("search window beyond used entries");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

endmodule

@@ rtl/table_linear_interpolator_unit.sv @@
// Top level of the table linear interpolator: entry count register, front and back.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  req_type, req_entry_*, req_measured_resistance
//   rsp       out        rsp_valid / rsp_stall  rsp_temperature
//   csr       in         csr_we                 csr_wdata (entries_used)
//
// A load item writes the table as it leaves the queue. A convert item leaves the
// queue, then runs a binary search of at most floor(log2(entries_used))+1 probes.
// A clamped result then goes through the pick, lower read and output states; an
// interpolated one also reads the upper neighbour, multiplies and runs the 44-step
// serial divider. Any result waits in the output state while the result stalls.
// Reset is synchronous; the table is not cleared. A two-item queue lets the front
// accept items while the back works or the result stalls, until the queue is full.
module table_linear_interpolator_unit #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic [tli_pkg::IDX_W-1:0]         req_entry_index,
   input  logic [tli_pkg::RES_W-1:0]         req_entry_resistance,
   input  logic signed [tli_pkg::TEMP_W-1:0] req_entry_temperature,
   input  logic [tli_pkg::RES_W-1:0]         req_measured_resistance,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [tli_pkg::TEMP_W-1:0] rsp_temperature,
   input  logic                              csr_we,
   input  logic [tli_pkg::CSR_W-1:0]         csr_wdata
);
   import tli_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int NW     = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   logic [CSR_W-1:0]  entries_used_ff, entries_used_in;
   logic [NW-1:0]     csr_wide;
   logic [CNT_W-1:0]  n_used;
   logic              q_valid, q_pop;
   queue_item_type    q_item;
   logic [ADDR_W-1:0] q_addr;

   // Entry count register
   assign entries_used_in = csr_we ? csr_wdata : entries_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_used_ff <= CSR_W'(1);
      end else begin
         entries_used_ff <= entries_used_in;
      end
   end

   // Clamp the count to one .. TABLE_DEPTH
   assign csr_wide = NW'(entries_used_ff);

   always_comb begin
      if (entries_used_ff == '0) begin
         n_used = CNT_W'(1);
      end else if (csr_wide > NW'(TABLE_DEPTH)) begin
         n_used = CNT_W'(TABLE_DEPTH);
      end else begin
         n_used = CNT_W'(csr_wide);
      end
   end

   tli_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_type                (req_type),
      .req_entry_index         (req_entry_index),
      .req_entry_resistance    (req_entry_resistance),
      .req_entry_temperature   (req_entry_temperature),
      .req_measured_resistance (req_measured_resistance),
      .q_valid                 (q_valid),
      .q_item                  (q_item),
      .q_addr                  (q_addr),
      .q_pop                   (q_pop)
   );

   tli_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_addr          (q_addr),
      .q_pop           (q_pop),
      .n_used          (n_used),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_temperature (rsp_temperature)
   );

endmodule

@@ tb/table_linear_interpolator_unit_test.sv @@
// Self-checking testbench for the table linear interpolator: table loads, conversions, stalls.
module table_linear_interpolator_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tli_pkg::*;

   localparam int DEPTH        = 1024;
   localparam int RANDOM_ITEMS = 750;
   localparam int SETTLE       = 250;
   localparam int CYCLE_LIMIT  = 1_000_000;

   // Mirror of the table and entry count, predicting one temperature per conversion
   class temperature_tracker;
      logic [RES_W-1:0]         res_tab [DEPTH];
      logic signed [TEMP_W-1:0] temp_tab [DEPTH];
      int unsigned              entries_used;
      logic signed [TEMP_W-1:0] pending_temps [$];
      int                       failures;

      function new();
         entries_used = 1;
         failures     = 0;
      endfunction

      function void set_entry_count(logic [CSR_W-1:0] value);
         entries_used = value;
      endfunction

      // Upper-bound search for the first entry above the sample, then interpolate
      function logic signed [TEMP_W-1:0] interpolate(logic [RES_W-1:0] meas);
         int unsigned n, first, count, half, probe;
         longint      t_lo, t_hi, r_lo, r_hi, span, num, quo, val;
         n = entries_used;
         if (n < 1) n = 1;
         if (n > DEPTH) n = DEPTH;
         first = 0;
         count = n;
         while (count > 0) begin
            half  = count / 2;
            probe = first + half;
            if (meas >= res_tab[probe]) begin
               first = probe + 1;
               count -= half + 1;
            end else begin
               count = half;
            end
         end
         if (first >= n) return temp_tab[n-1];
         if (first == 0) return temp_tab[0];
         t_lo = temp_tab[first-1];
         t_hi = temp_tab[first];
         r_lo = res_tab[first-1];
         r_hi = res_tab[first];
         span = r_hi - r_lo;
         if (span <= 0) return temp_tab[first-1];
         num = (t_hi - t_lo) * (longint'(meas) - r_lo);
         // quotient truncates toward zero
         quo = (num < 0 ? -num : num) / span;
         val = (num < 0) ? t_lo - quo : t_lo + quo;
         if (val > longint'(TEMP_MAX)) val = TEMP_MAX;
         if (val < longint'(TEMP_MIN)) val = TEMP_MIN;
         return val[TEMP_W-1:0];
      endfunction

      function void note_item(logic kind, logic [IDX_W-1:0] idx, logic [RES_W-1:0] res,
                              logic signed [TEMP_W-1:0] temp, logic [RES_W-1:0] meas);
         if (kind == REQ_LOAD) begin
            if (idx < DEPTH) begin
               res_tab[idx]  = res;
               temp_tab[idx] = temp;
            end
         end else begin
            pending_temps.push_back(interpolate(meas));
         end
      endfunction

      function void check_result(logic signed [TEMP_W-1:0] got);
         logic signed [TEMP_W-1:0] want;
         if (pending_temps.size() == 0) begin
            $error("temperature: expected none, got %0d", got);
            failures++;
            return;
         end
         want = pending_temps[0];
         pending_temps.delete(0);
         if (got !== want) begin
            $error("temperature: expected %0d, got %0d", want, got);
            failures++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_type = REQ_LOAD;
   logic [IDX_W-1:0]          req_entry_index = '0;
   logic [RES_W-1:0]          req_entry_resistance = '0;
   logic signed [TEMP_W-1:0]  req_entry_temperature = '0;
   logic [RES_W-1:0]          req_measured_resistance = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [TEMP_W-1:0]  rsp_temperature;
   logic                      csr_we = 1'b0;
   logic [CSR_W-1:0]          csr_wdata = '0;

   temperature_tracker        tracker;
   logic [RES_W-1:0]          known_res [DEPTH];
   int                        gap_pct = 28;
   int                        stall_pct = 59;
   int                        items_sent = 0;
   int                        cycle_count = 0;

   table_linear_interpolator_unit #(
      .TABLE_DEPTH(DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_entry_index(req_entry_index),
      .req_entry_resistance(req_entry_resistance),
      .req_entry_temperature(req_entry_temperature),
      .req_measured_resistance(req_measured_resistance),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_temperature(rsp_temperature),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Observe register writes, accepted items and results; watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) tracker.set_entry_count(csr_wdata);
         if (req_valid && !req_stall)
            tracker.note_item(req_type, req_entry_index, req_entry_resistance,
                              req_entry_temperature, req_measured_resistance);
         if (rsp_valid && !rsp_stall) tracker.check_result(rsp_temperature);
      end
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // One item: random idle cycles first, then hold until accepted
   task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx,
                            input logic [RES_W-1:0] res, input logic signed [TEMP_W-1:0] temp,
                            input logic [RES_W-1:0] meas);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_type                <= kind;
      req_entry_index         <= idx;
      req_entry_resistance    <= res;
      req_entry_temperature   <= temp;
      req_measured_resistance <= meas;
      if (kind == REQ_LOAD) known_res[idx] = res;
      items_sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic load_entry(input int idx, input logic [RES_W-1:0] res,
                             input logic signed [TEMP_W-1:0] temp);
      send_item(REQ_LOAD, IDX_W'(idx), res, temp, RES_W'($urandom));
   endtask

   // Don't-care fields of a conversion carry random bits
   task automatic convert_sample(input logic [RES_W-1:0] meas);
      send_item(REQ_CONVERT, IDX_W'($urandom), RES_W'($urandom), TEMP_W'($urandom), meas);
   endtask

   // Stop sending, wait for every outstanding result, then let the back end go quiet
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_temps.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_count(input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Load entries 0..k-1: ascending resistances (with repeats) or random ones
   task automatic build_table(input int k, input bit ordered);
      int unsigned stride, acc;
      logic signed [TEMP_W-1:0] temp;
      stride = 16_000_000 / (k + 1);
      acc    = $urandom_range(0, stride);
      for (int i = 0; i < k; i++) begin
         case ($urandom_range(0, 9))
            0:       temp = TEMP_MAX;
            1:       temp = TEMP_MIN;
            default: temp = TEMP_W'($urandom);
         endcase
         load_entry(i, ordered ? acc[RES_W-1:0] : RES_W'($urandom), temp);
         if ($urandom_range(0, 9) != 0) acc += $urandom_range(1, stride);
      end
   endtask

   initial begin
      int          random_start, random_sent, n, j;
      logic [CSR_W-1:0] count_value;
      logic [RES_W-1:0] meas;
      bit          first_phase;
      tracker = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single entry after reset: both clamps
      load_entry(0, 24'h001000, TEMP_MAX);
      convert_sample(24'h000000);
      convert_sample(24'hFFFFFF);
      drain_and_settle();
      // a count of zero behaves as one; a sample equal to the entry is not below it
      write_count(11'd0);
      convert_sample(24'h001000);
      drain_and_settle();

      // Four entries at the field extremes
      write_count(11'd4);
      load_entry(0, 24'h000000, TEMP_MIN);
      load_entry(1, 24'h000100, TEMP_MAX);
      load_entry(2, 24'h800000, 19'sd0);
      load_entry(3, 24'hFFFFFF, -19'sd256);
      convert_sample(24'h000000);
      convert_sample(24'h000080);
      convert_sample(24'h400000);
      // negative slope: truncation toward zero
      convert_sample(24'hFFFFFE);
      convert_sample(24'hFFFFFF);
      convert_sample(24'h000100);
      // unsorted table: answer follows the fixed search order
      load_entry(1, 24'h900000, 19'sh12345);
      convert_sample(24'h850000);
      convert_sample(24'h000100);
      convert_sample(24'h8FFFFF);
      drain_and_settle();

      // Fill the whole table so any entry count is safe from here on
      write_count(11'd1024);
      build_table(DEPTH, 1'b1);

      random_start = items_sent;
      random_sent  = 0;
      first_phase  = 1'b1;
      while (random_sent < RANDOM_ITEMS) begin
         drain_and_settle();
         case (3 * random_sent / RANDOM_ITEMS)
            0: begin
               gap_pct   = 28;
               stall_pct = 59;
            end
            1: begin
               gap_pct   = 59;
               stall_pct = 28;
            end
            default: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
         endcase
         if (first_phase) begin
            count_value = 11'd2047;
         end else begin
            case ($urandom_range(0, 19))
               0:       count_value = 11'd0;
               1:       count_value = 11'd1;
               2:       count_value = 11'd1024;
               3:       count_value = CSR_W'($urandom_range(1025, 2047));
               4, 5:    count_value = CSR_W'($urandom_range(65, 1023));
               6, 7, 8, 9: count_value = CSR_W'($urandom_range(9, 64));
               default: count_value = CSR_W'($urandom_range(2, 8));
            endcase
         end
         first_phase = 1'b0;
         write_count(count_value);
         n = (count_value == 0) ? 1 : (count_value > DEPTH) ? DEPTH : count_value;
         if (n <= 64) build_table(n, $urandom_range(0, 6) != 0);

         repeat ($urandom_range(5, 30)) begin
            if ($urandom_range(0, 9) == 0) begin
               // stray rewrite of a used entry
               load_entry($urandom_range(0, n - 1), RES_W'($urandom), TEMP_W'($urandom));
            end else begin
               j = $urandom_range(0, n - 1);
               case ($urandom_range(0, 5))
                  0: meas = known_res[j];
                  1: meas = known_res[j] - 24'd1;
                  2: begin
                     if (j + 1 < n && known_res[j+1] > known_res[j])
                        meas = RES_W'($urandom_range(known_res[j], known_res[j+1] - 1));
                     else
                        meas = known_res[j] + 24'd1;
                  end
                  3: meas = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
                  default: meas = RES_W'($urandom);
               endcase
               convert_sample(meas);
            end
         end
         random_sent = items_sent - random_start;
      end

      drain_and_settle();
      if (tracker.failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/tli_pkg.sv
rtl/tli_front.sv
rtl/tli_div.sv
rtl/tli_back.sv
rtl/table_linear_interpolator_unit.sv
tb/table_linear_interpolator_unit_test.sv
